### hw/rtl/metf_pkg.sv
// ----------------------------------------------------------------------------
// metf_pkg
// Types and constants shared by the MIDI event trigger filter.
// ----------------------------------------------------------------------------
package metf_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgMatchStatus  = 3'd0,
    CfgMatchChannel = 3'd1,
    CfgTestModeOne  = 3'd2,
    CfgTestModeTwo  = 3'd3,
    CfgReferenceOne = 3'd4,
    CfgReferenceTwo = 3'd5
  } cfg_reg_e;

  // data byte test modes, codes above never match
  typedef enum logic [3:0] {
    TestAny     = 4'd0,
    TestEqual   = 4'd1,
    TestNotEq   = 4'd2,
    TestGreater = 4'd3,
    TestLess    = 4'd4,
    TestLessEq  = 4'd5,
    TestGreatEq = 4'd6,
    TestChange  = 4'd7,
    TestNever   = 4'd8
  } test_mode_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 9;

  // reset values of the registers
  localparam logic [8:0] MatchStatusReset  = 9'd144;
  localparam logic [4:0] MatchChannelReset = 5'h1F;
  localparam logic [4:0] ChannelAny        = 5'h1F;

  // floor(d * k / 127) as (d * k * 33027) >> 22, exact for d * k below 33555
  localparam int unsigned RecipShift   = 22;
  localparam int unsigned ScaleWidth   = 30;
  localparam logic [ScaleWidth-1:0] PercentMult = ScaleWidth'(100 * 33027);
  localparam logic [ScaleWidth-1:0] ByteMult    = ScaleWidth'(255 * 33027);

  // one result item
  typedef struct packed {
    logic       fired;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [6:0] percent_one;
    logic [6:0] percent_two;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
  } result_t;

  // scale a data byte by a constant over 127, floor
  function automatic logic [7:0] scale_byte(input logic [6:0] d,
                                            input logic [ScaleWidth-1:0] mult);
    logic [ScaleWidth-1:0] prod;
    prod = ScaleWidth'(d) * mult;
    return prod[RecipShift +: 8];
  endfunction

  // one data byte test
  function automatic logic data_test(input logic [3:0] mode, input logic [6:0] value,
                                     input logic [6:0] ref_val, input logic [6:0] last);
    logic pass;
    unique case (mode)
      TestAny:     pass = 1'b1;
      TestEqual:   pass = (value == ref_val);
      TestNotEq:   pass = (value != ref_val);
      TestGreater: pass = (value > ref_val);
      TestLess:    pass = (value < ref_val);
      TestLessEq:  pass = (value <= ref_val);
      TestGreatEq: pass = (value >= ref_val);
      TestChange:  pass = (value != last);
      default:     pass = 1'b0;
    endcase
    return pass;
  endfunction

endpackage

### hw/rtl/midi_event_trigger_filter_core.sv
// ----------------------------------------------------------------------------
// midi_event_trigger_filter_core
// Matches decoded MIDI messages against a configured trigger and scales the
// data bytes to percent and full byte range.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid_i / in_stall_o with status, channel, two data
//                    bytes; an item is taken when valid is high, stall low
//   output channel : out_valid_o / out_stall_i with the fire flag, both data
//                    bytes and their scaled values, one result per item
//   config port    : cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
//                    write only while no item is in flight
// Accepted items are registered in the output or skid register, one per cycle
// while in_stall_o is low; trigger test and last-value update complete in the
// accepting cycle, so back-to-back on-change tests see up-to-date values.
// A stalled receiver holds the result in the output register; one further
// item is parked in a skid register, after which in_stall_o rises.
// Reset empties both registers, loads the register defaults (status 144,
// any channel, both tests "any", references zero) and clears the last
// fired data bytes.
// ----------------------------------------------------------------------------
module midi_event_trigger_filter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [metf_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [metf_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        status_byte_i,
  input  logic [3:0]                        channel_num_i,
  input  logic [6:0]                        data_one_i,
  input  logic [6:0]                        data_two_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              fired_o,
  output logic [6:0]                        out_data_one_o,
  output logic [6:0]                        out_data_two_o,
  output logic [6:0]                        percent_one_o,
  output logic [6:0]                        percent_two_o,
  output logic [7:0]                        byte_one_o,
  output logic [7:0]                        byte_two_o
);

  // configuration registers
  logic [8:0] match_status_q;
  logic [4:0] match_channel_q;
  logic [3:0] test_mode_one_q;
  logic [3:0] test_mode_two_q;
  logic [6:0] reference_one_q;
  logic [6:0] reference_two_q;

  // last fired data bytes
  logic [6:0] last_one_q;
  logic [6:0] last_two_q;

  // output and skid registers
  logic              out_valid_q, skid_valid_q;
  metf_pkg::result_t out_q, skid_q;

  logic              in_acc, out_acc, out_free;
  logic              status_ok, channel_ok, fire;
  metf_pkg::result_t res;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || out_acc;

  // configuration writes, unlisted indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_status_q  <= metf_pkg::MatchStatusReset;
      match_channel_q <= metf_pkg::MatchChannelReset;
      test_mode_one_q <= metf_pkg::TestAny;
      test_mode_two_q <= metf_pkg::TestAny;
      reference_one_q <= '0;
      reference_two_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        metf_pkg::CfgMatchStatus:  match_status_q  <= cfg_wdata_i;
        metf_pkg::CfgMatchChannel: match_channel_q <= cfg_wdata_i[4:0];
        metf_pkg::CfgTestModeOne:  test_mode_one_q <= cfg_wdata_i[3:0];
        metf_pkg::CfgTestModeTwo:  test_mode_two_q <= cfg_wdata_i[3:0];
        metf_pkg::CfgReferenceOne: reference_one_q <= cfg_wdata_i[6:0];
        metf_pkg::CfgReferenceTwo: reference_two_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // trigger decision, negative status or channel codes never match
  always_comb begin
    status_ok  = !match_status_q[8] && (match_status_q[7:0] == status_byte_i);
    channel_ok = (match_channel_q == metf_pkg::ChannelAny) ||
                 (!match_channel_q[4] && (match_channel_q[3:0] == channel_num_i));
    fire = status_ok && channel_ok &&
           metf_pkg::data_test(test_mode_one_q, data_one_i, reference_one_q, last_one_q) &&
           metf_pkg::data_test(test_mode_two_q, data_two_i, reference_two_q, last_two_q);
  end

  // result item
  always_comb begin
    logic [7:0] pct_one, pct_two;
    pct_one         = metf_pkg::scale_byte(data_one_i, metf_pkg::PercentMult);
    pct_two         = metf_pkg::scale_byte(data_two_i, metf_pkg::PercentMult);
    res.fired       = fire;
    res.data_one    = data_one_i;
    res.data_two    = data_two_i;
    res.percent_one = pct_one[6:0];
    res.percent_two = pct_two[6:0];
    res.byte_one    = metf_pkg::scale_byte(data_one_i, metf_pkg::ByteMult);
    res.byte_two    = metf_pkg::scale_byte(data_two_i, metf_pkg::ByteMult);
  end

  // last values kept only on a fire
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_one_q <= '0;
      last_two_q <= '0;
    end else if (in_acc && fire) begin
      last_one_q <= data_one_i;
      last_two_q <= data_two_i;
    end
  end

  // output and skid occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q && out_free) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q && out_free) begin
      out_q <= skid_q;
    end else if (in_acc) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign fired_o        = out_q.fired;
  assign out_data_one_o = out_q.data_one;
  assign out_data_two_o = out_q.data_two;
  assign percent_one_o  = out_q.percent_one;
  assign percent_two_o  = out_q.percent_two;
  assign byte_one_o     = out_q.byte_one;
  assign byte_two_o     = out_q.byte_two;

`ifndef NO_ASSERTIONS
  // skid register only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // a fire records the accepted data bytes
  a_last_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fire) |=> (last_one_q == $past(data_one_i) &&
                          last_two_q == $past(data_two_i)))
    else $error("last values not updated on fire");

  // no fire leaves the last values alone
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && fire) |=> ($stable(last_one_q) && $stable(last_two_q)))
    else $error("last values changed without a fire");

  // draining with nothing behind empties the output register
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !skid_valid_q && !in_acc) |=> !out_valid_q)
    else $error("output register still valid after drain");
`endif

endmodule
